// ----- rtl/cfs_pkg.sv -----
// shared types and constants for the cue fade scheduler
`default_nettype none
package cfs_pkg;
	localparam logic [1:0] CMD_ADD     = 2'd0;
	localparam logic [1:0] CMD_ADVANCE = 2'd1;
	localparam logic [1:0] CMD_SET     = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_DROPPED = 3'd1;
	localparam logic [2:0] KIND_ACTIVE  = 3'd2;
	localparam logic [2:0] KIND_NONE    = 3'd3;
	localparam logic [2:0] KIND_CLEARED = 3'd4;

	// byte addresses of the configuration registers
	localparam logic [2:0] ADDR_KEEP_SORTED  = 3'd0;
	localparam logic [2:0] ADDR_MAX_REPORTED = 3'd4;

	localparam logic [16:0] Q15_ONE = 17'd32768;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] cue_start;
		logic [31:0] cue_end;
		logic [31:0] cue_fade_in;
		logic [31:0] cue_fade_out;
		logic [15:0] cue_tag;
		logic [31:0] time_value;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] active_tag;
		logic [15:0] opacity;
		logic        last;
	} result_t;
endpackage
`default_nettype wire

// ----- rtl/cue_fade_scheduler_top.sv -----
// top level of the cue fade scheduler
// A table of up to CUE_SLOTS cues plus a 32-bit timeline clock. Words enter through
// a registered front stage and a two-entry queue before the back sequencer takes
// them. In the back an append writes the new entry at the end of the table, a sorted
// add scans one entry a cycle for the insert point and then shifts one entry a cycle,
// and a drop or a clear goes straight to its result word. A time change walks the
// cues; a cue needs 0 to 2 fade divides through one shared 48-step restoring divider
// and a multiply step per fade-out product, and fewer cues are walked once the report
// limit is reached. One active word is held back until the next one is found so that
// the final word can carry last. A result word waiting in the output register stalls
// the back when it has another word to load, and the next word waits in the queue
// meanwhile.
`default_nettype none
module cue_fade_scheduler_top
	import cfs_pkg::*;
#(
	parameter int CUE_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [31:0] cue_start,
	input  wire logic [31:0] cue_end,
	input  wire logic [31:0] cue_fade_in,
	input  wire logic [31:0] cue_fade_out,
	input  wire logic [15:0] cue_tag,
	input  wire logic [31:0] time_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [15:0]      active_tag,
	output logic [15:0]      opacity,
	output logic             last
);
	logic       keep_sorted_q;
	logic [4:0] max_reported_q;
	item_t      in_item, f_data, b_data;
	logic       f_valid, f_ready, b_valid, b_ready;
	result_t    res;

	assign pready = 1'b1;
	// registers at byte 0 and 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_sorted_q <= 1'b1; max_reported_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_KEEP_SORTED) keep_sorted_q <= pwdata[0];
			else if (paddr == ADDR_MAX_REPORTED) max_reported_q <= pwdata[4:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_KEEP_SORTED) prdata[0] = keep_sorted_q;
		else if (paddr == ADDR_MAX_REPORTED) prdata[4:0] = max_reported_q;
	end

	assign in_item = '{cmd, cue_start, cue_end, cue_fade_in, cue_fade_out, cue_tag,
		time_value};

	cfs_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready), .item(in_item),
		.q_data(f_data), .q_valid(f_valid), .q_ready(f_ready)
	);
	cfs_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_data(f_data), .wr_valid(f_valid),
		.wr_ready(f_ready), .rd_data(b_data), .rd_valid(b_valid), .rd_ready(b_ready)
	);
	cfs_back #(.CUE_SLOTS(CUE_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .keep_sorted(keep_sorted_q),
		.max_reported(max_reported_q), .in_data(b_data), .in_valid(b_valid),
		.in_ready(b_ready), .res_data(res), .res_valid(out_valid), .res_ready(out_ready)
	);

	assign kind       = res.kind;
	assign active_tag = res.active_tag;
	assign opacity    = res.opacity;
	assign last       = res.last;
endmodule
`default_nettype wire

// ----- rtl/cfs_fifo.sv -----
// short word queue between the front and back parts
`default_nettype none
module cfs_fifo
	import cfs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t wr_data,
	input  wire logic  wr_valid,
	output logic       wr_ready,
	output item_t      rd_data,
	output logic       rd_valid,
	input  wire logic  rd_ready
);
	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/cfs_div.sv -----
// radix-2 restoring divider, 48-bit dividend by 32-bit divisor
`default_nettype none
module cfs_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [47:0]      quotient
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;

	assign shifted  = {rem_q[31:0], quo_q[47]};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; cnt_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; cnt_q <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend; rem_q <= '0; dvs_q <= divisor;
		end else if (busy_q) begin
			if (shifted >= {1'b0, dvs_q}) begin
				rem_q <= shifted - {1'b0, dvs_q};
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/cfs_back.sv -----
// back part: cue table, clock and opacity reporting sequencer
`default_nettype none
module cfs_back
	import cfs_pkg::*;
#(
	parameter int CUE_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        keep_sorted,
	input  wire logic [4:0]  max_reported,
	input  wire item_t       in_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	output result_t          res_data,
	output logic             res_valid,
	input  wire logic        res_ready
);
	localparam int IW = $clog2(CUE_SLOTS);
	localparam int CW = $clog2(CUE_SLOTS + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_SHIFT = 4'd2;
	localparam logic [3:0] ST_RD    = 4'd3;
	localparam logic [3:0] ST_EVAL  = 4'd4;
	localparam logic [3:0] ST_DIVI  = 4'd5;
	localparam logic [3:0] ST_DIVO  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;
	localparam logic [3:0] ST_NEXT  = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;
	localparam logic [3:0] ST_OUT   = 4'd11;

	logic [3:0]    st_q;
	logic [IW-1:0] idx_q, pos_q;
	logic [CW-1:0] total_q;
	logic [31:0]   now_q;
	item_t         cur_q;
	logic [4:0]    found_q, limit_q;

	logic [31:0] st_mem [CUE_SLOTS];
	logic [31:0] en_mem [CUE_SLOTS];
	logic [31:0] fi_mem [CUE_SLOTS];
	logic [31:0] fo_mem [CUE_SLOTS];
	logic [15:0] tg_mem [CUE_SLOTS];

	logic [31:0] s_q, e_q, fi_q, fo_q;
	logic [15:0] tg_q;
	logic [16:0] op_q, f_q;
	logic        fo_pend_q;
	result_t     pend_q;
	logic        hold_v_q;
	logic [15:0] hold_tag_q, hold_op_q;

	logic        div_start;
	logic [47:0] div_dvd;
	logic [31:0] div_dvs;
	logic        div_done;
	logic [47:0] div_quo;

	cfs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quotient(div_quo)
	);

	logic [32:0]   adv_sum;
	logic [32:0]   fi_end;
	logic [32:0]   t_plus_fo;
	logic          active_in;
	logic          fi_cond, fo_cond;
	logic          out_free;
	logic          res_load;
	result_t       res_word;
	logic [33:0]   prod;
	logic [IW-1:0] last_idx;

	assign adv_sum   = {1'b0, now_q} + {1'b0, in_data.time_value};
	assign fi_end    = {1'b0, s_q} + {1'b0, fi_q};
	assign t_plus_fo = {1'b0, now_q} + {1'b0, fo_q};
	assign active_in = !(now_q < s_q || now_q > e_q);
	assign fi_cond   = (fi_q != 32'd0) && ({1'b0, now_q} < fi_end);
	assign fo_cond   = (fo_q != 32'd0) && (t_plus_fo > {1'b0, e_q});
	assign prod      = op_q * f_q;
	assign last_idx  = IW'(total_q - CW'(1));
	assign out_free  = !res_valid || res_ready;

	assign in_ready = (st_q == ST_IDLE);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = {1'b0, now_q - s_q, 15'd0};
		div_dvs   = fi_q;
		if (st_q == ST_EVAL && active_in && fi_cond) begin
			div_start = 1'b1;
		end else if ((st_q == ST_EVAL && active_in && fo_cond)
				|| (st_q == ST_DIVI && div_done && fo_pend_q)) begin
			div_start = 1'b1;
			div_dvd   = {1'b0, e_q - now_q, 15'd0};
			div_dvs   = fo_q;
		end
	end

	// one active word is held back until it is known whether another follows
	always_comb begin
		res_load = 1'b0;
		res_word = pend_q;
		if (st_q == ST_OUT) begin
			res_load = out_free;
		end else if (st_q == ST_EMIT) begin
			res_load = out_free && hold_v_q && (op_q != '0);
			res_word = result_t'{KIND_ACTIVE, hold_tag_q, hold_op_q, 1'b0};
		end else if (st_q == ST_FIN) begin
			res_load = out_free;
			if (hold_v_q) res_word = result_t'{KIND_ACTIVE, hold_tag_q, hold_op_q, 1'b1};
			else res_word = result_t'{KIND_NONE, 16'd0, 16'd0, 1'b1};
		end
	end

	// clamp a reported opacity to one
	function automatic logic [15:0] clamp_op(input logic [47:0] v);
		clamp_op = (v > 48'(Q15_ONE)) ? 16'h8000 : v[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (st_q == ST_SHIFT) begin
			if (idx_q > pos_q) begin
				st_mem[idx_q] <= st_mem[idx_q - IW'(1)];
				en_mem[idx_q] <= en_mem[idx_q - IW'(1)];
				fi_mem[idx_q] <= fi_mem[idx_q - IW'(1)];
				fo_mem[idx_q] <= fo_mem[idx_q - IW'(1)];
				tg_mem[idx_q] <= tg_mem[idx_q - IW'(1)];
			end else begin
				st_mem[pos_q] <= cur_q.cue_start;
				en_mem[pos_q] <= cur_q.cue_end;
				fi_mem[pos_q] <= cur_q.cue_fade_in;
				fo_mem[pos_q] <= cur_q.cue_fade_out;
				tg_mem[pos_q] <= cur_q.cue_tag;
			end
		end
		if (st_q == ST_RD) begin
			s_q  <= st_mem[idx_q];
			e_q  <= en_mem[idx_q];
			fi_q <= fi_mem[idx_q];
			fo_q <= fo_mem[idx_q];
			tg_q <= tg_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0; res_data <= '0;
		end else if (res_load) begin
			res_data  <= res_word;
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; total_q <= '0; now_q <= '0;
			idx_q <= '0; pos_q <= '0; found_q <= '0; limit_q <= 5'd1;
			fo_pend_q <= 1'b0; op_q <= '0; f_q <= '0;
			cur_q <= '0; pend_q <= '0;
			hold_v_q <= 1'b0; hold_tag_q <= '0; hold_op_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					cur_q <= in_data;
					idx_q <= '0;
					found_q <= '0;
					hold_v_q <= 1'b0;
					limit_q <= (max_reported == 5'd0) ? 5'd1 :
						(max_reported > 5'd16) ? 5'd16 : max_reported;
					unique case (in_data.cmd)
						CMD_ADD: begin
							if (total_q == CW'(CUE_SLOTS)) begin
								pend_q <= '{KIND_DROPPED, 16'd0, 16'd0, 1'b1};
								st_q <= ST_OUT;
							end else if (keep_sorted && total_q != '0) begin
								st_q <= ST_SCAN;
							end else begin
								pos_q <= IW'(total_q);
								idx_q <= IW'(total_q);
								st_q <= ST_SHIFT;
							end
						end
						CMD_ADVANCE: begin
							// saturate at the top of the timeline
							now_q <= adv_sum[32] ? 32'hffffffff : adv_sum[31:0];
							st_q <= ST_RD;
						end
						CMD_SET: begin
							now_q <= in_data.time_value;
							st_q <= ST_RD;
						end
						CMD_CLEAR: begin
							total_q <= '0;
							pend_q <= '{KIND_CLEARED, 16'd0, 16'd0, 1'b1};
							st_q <= ST_OUT;
						end
					endcase
				end
				ST_SCAN: begin
					// first entry with a later start is the insert point
					if (idx_q == last_idx) begin
						if (st_mem[idx_q] <= cur_q.cue_start) pos_q <= IW'(total_q);
						else pos_q <= idx_q;
						idx_q <= IW'(total_q);
						st_q <= ST_SHIFT;
					end else if (st_mem[idx_q] > cur_q.cue_start) begin
						pos_q <= idx_q;
						idx_q <= IW'(total_q);
						st_q <= ST_SHIFT;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_SHIFT: begin
					if (idx_q > pos_q) idx_q <= idx_q - IW'(1);
					else begin
						total_q <= total_q + CW'(1);
						pend_q <= '{KIND_ADDED, 16'd0, 16'd0, 1'b1};
						st_q <= ST_OUT;
					end
				end
				ST_RD: begin
					if (CW'(idx_q) >= total_q) st_q <= ST_FIN;
					else st_q <= ST_EVAL;
				end
				ST_EVAL: begin
					fo_pend_q <= fo_cond;
					if (!active_in) begin
						op_q <= '0;
						st_q <= ST_EMIT;
					end else if (fi_cond) begin
						st_q <= ST_DIVI;
					end else if (fo_cond) begin
						op_q <= Q15_ONE;
						st_q <= ST_DIVO;
					end else begin
						op_q <= Q15_ONE;
						st_q <= ST_EMIT;
					end
				end
				ST_DIVI: if (div_done) begin
					op_q <= {1'b0, clamp_op(div_quo)};
					st_q <= fo_pend_q ? ST_DIVO : ST_EMIT;
				end
				ST_DIVO: if (div_done) begin
					f_q <= {1'b0, clamp_op(div_quo)};
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					op_q <= prod[31:15];
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (op_q == '0) begin
						st_q <= ST_NEXT;
					end else if (!hold_v_q || out_free) begin
						hold_v_q <= 1'b1;
						hold_tag_q <= tg_q;
						hold_op_q <= op_q[15:0];
						found_q <= found_q + 5'd1;
						st_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (found_q >= limit_q || CW'(idx_q) + CW'(1) >= total_q) begin
						st_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + IW'(1);
						st_q <= ST_RD;
					end
				end
				ST_FIN: if (out_free) begin
					hold_v_q <= 1'b0;
					st_q <= ST_IDLE;
				end
				ST_OUT: if (out_free) begin
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/cfs_front.sv -----
// front part: input handshake and command classification into the queue
`default_nettype none
module cfs_front
	import cfs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             ready,
	input  wire item_t       item,
	output item_t            q_data,
	output logic             q_valid,
	input  wire logic        q_ready
);
	item_t full_q;
	logic  full_v_q;
	item_t cls;

	assign ready   = !full_v_q || q_ready;
	assign q_data  = full_q;
	assign q_valid = full_v_q;

	// every command but add carries only the time value
	always_comb begin
		cls = item;
		if (item.cmd != CMD_ADD) begin
			cls.cue_start    = '0;
			cls.cue_end      = '0;
			cls.cue_fade_in  = '0;
			cls.cue_fade_out = '0;
			cls.cue_tag      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_v_q <= 1'b0; full_q <= '0;
		end else if (ready) begin
			full_v_q <= valid;
			full_q   <= cls;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/cfs_checker.sv -----
// port-level checker for the cue fade scheduler
`default_nettype none
module cfs_checker
	import cfs_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  kind,
	input wire logic [15:0] opacity,
	input wire logic        last,
	input wire logic        pready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind))
		else $error("result word dropped while stalled");
	a_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> opacity <= 16'h8000)
		else $error("opacity above one");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_ACTIVE |-> last)
		else $error("single word result without last");
	a_rdy: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind cue_fade_scheduler_top cfs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.kind(kind), .opacity(opacity), .last(last), .pready(pready)
);
`default_nettype wire
